@@ design/drg_pkg.sv @@
package drg_pkg;

    localparam logic [31:0] MULT_ODD   = 32'd1588635695;
    localparam logic [31:0] MULT_HALF  = 32'd1117695901;
    localparam logic [33:0] SCALE_DIV  = 34'd4294967291;
    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam int          TOTAL_MAX  = 16777215;
    localparam int          TOTAL_MIN  = -16777216;

    localparam logic        REG_SEED   = 1'b0;

endpackage

@@ design/dice_roll_generator.sv @@
// Channel   Dir  Handshake                   Payload
// request   in   i_in_valid / o_in_ready     i_dice_count, i_low_value, i_high_value
// result    out  o_out_valid / i_out_ready   o_total
// config    in   psel / penable / pready     paddr, pwrite, pwdata, prdata
//
// Each die runs ADV, SEED, SCALE, DIV and ACC (a zero count skips them); each die
// uses the shared multiplier twice, once for the seed step and once for scaling.
// The result register holds its transfer until taken; a new request is taken
// while it waits, but the final load stalls until the register is free.
// Synchronous active-low reset loads the seed with 1 and clears all control.
module dice_roll_generator #(
    parameter int MAX_DICE = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_dice_count,
    input  logic signed [15:0] i_low_value,
    input  logic signed [15:0] i_high_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [24:0] o_total,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CNT_MAX = (MAX_DICE < 255) ? MAX_DICE : 255;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int ACC_W   = 19 + CNT_W;
    localparam int SAT_W   = (ACC_W > 26) ? ACC_W : 26;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(drg_pkg::TOTAL_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(drg_pkg::TOTAL_MIN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_SEED,
        S_SCALE,
        S_DIV,
        S_ACC,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [31:0]              r_init_seed;
    logic [31:0]              r_seed;
    logic [CNT_W-1:0]         r_left;
    logic signed [15:0]       r_low;
    logic signed [17:0]       r_span;
    logic signed [49:0]       r_prod;
    logic [16:0]              r_q0;
    logic [33:0]              r_rem;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [24:0]       r_total;

    logic [31:0]              mul_a;
    logic signed [31:0]       mul_b;
    logic signed [64:0]       mul_p;
    logic [48:0]              mag;
    logic [33:0]              n_rem;
    logic [17:0]              quo;
    logic signed [18:0]       quo_s;
    logic signed [18:0]       draw;
    logic signed [SAT_W-1:0]  acc_ext;
    logic signed [24:0]       n_total;
    logic [CNT_W-1:0]         cnt_clamp;
    logic                     cfg_wr;
    logic                     in_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_total     = r_total;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && (paddr[2] == drg_pkg::REG_SEED);
    assign prdata      = (paddr[2] == drg_pkg::REG_SEED) ? r_init_seed : 32'd0;

    assign cnt_clamp = (int'(i_dice_count) > CNT_MAX) ? CNT_W'(CNT_MAX)
                                                      : CNT_W'(i_dice_count);

    // shared multiplier: seed step or seed * span
    always_comb begin
        if (r_state == S_SCALE) begin
            mul_a = r_seed;
            mul_b = 32'(r_span);
        end else begin
            mul_a = {1'b0, r_seed[31:1]};
            mul_b = $signed(drg_pkg::MULT_HALF);
        end
        mul_p = $signed({1'b0, mul_a}) * mul_b;
    end

    // divide by 2^32-5: q0 = mag>>32, rem = low32 + 5*q0 < 2*D
    assign mag   = r_prod[49] ? 49'(-r_prod) : r_prod[48:0];
    assign n_rem = {2'b0, mag[31:0]} + {15'b0, mag[48:32], 2'b0} + {17'b0, mag[48:32]};

    assign quo   = {1'b0, r_q0} + 18'(r_rem >= drg_pkg::SCALE_DIV);
    assign quo_s = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign draw  = quo_s + 19'(r_low);

    assign acc_ext = SAT_W'(r_acc);
    always_comb begin
        if (acc_ext > SAT_HI) begin
            n_total = SAT_HI[24:0];
        end else if (acc_ext < SAT_LO) begin
            n_total = SAT_LO[24:0];
        end else begin
            n_total = acc_ext[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_seed <= drg_pkg::SEED_RESET;
            r_seed      <= drg_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_init_seed <= pwdata;
                r_seed      <= pwdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_left  <= cnt_clamp;
                        r_low   <= i_low_value;
                        r_span  <= 18'(i_high_value) - 18'(i_low_value) + 18'sd1;
                        r_acc   <= '0;
                        r_state <= (i_dice_count == 8'd0) ? S_DONE : S_ADV;
                    end
                end
                S_ADV: begin
                    r_prod  <= mul_p[49:0];
                    r_state <= S_SEED;
                end
                S_SEED: begin
                    r_seed  <= (r_seed[0] ? drg_pkg::MULT_ODD : 32'd0) - r_prod[31:0];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= mul_p[49:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_q0    <= mag[48:32];
                    r_rem   <= n_rem;
                    r_neg   <= r_prod[49];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc  <= r_acc + ACC_W'(draw);
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_ADV;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_total     <= n_total;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/tb.sv @@
module tb;

    localparam int MAX_DICE = 255;

    typedef struct {
        logic [7:0]         count;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } t_roll_req;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_dice_count = '0;
    logic signed [15:0] i_low_value  = '0;
    logic signed [15:0] i_high_value = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic signed [24:0] o_total;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_roll_req          roll_q[$];
    logic signed [24:0] total_q[$];
    logic [31:0]        gen_seed      = drg_pkg::SEED_RESET;
    int                 rolls_pending = 0;
    int                 in_gap        = 0;
    int                 out_stall     = 0;
    int                 errors        = 0;
    bit                 calm          = 1'b0;
    longint             budget        = 0;
    longint             cycles        = 0;

    dice_roll_generator #(.MAX_DICE(MAX_DICE)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_dice_count(i_dice_count),
        .i_low_value (i_low_value),
        .i_high_value(i_high_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_total     (o_total),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic signed [24:0] predict_total(input logic [7:0] count,
                                                         input logic signed [15:0] lo,
                                                         input logic signed [15:0] hi);
        longint span;
        longint prod;
        longint sum;
        int     n;
        span = longint'(hi) - longint'(lo) + 1;
        sum  = 0;
        n    = (count > MAX_DICE) ? MAX_DICE : int'(count);
        for (int i = 0; i < n; i++) begin
            gen_seed = drg_pkg::MULT_ODD * {31'd0, gen_seed[0]}
                     - drg_pkg::MULT_HALF * {1'b0, gen_seed[31:1]};
            prod     = longint'({32'd0, gen_seed}) * span;
            sum      = sum + longint'(lo) + prod / longint'(drg_pkg::SCALE_DIV);
        end
        if (sum > drg_pkg::TOTAL_MAX)
            sum = drg_pkg::TOTAL_MAX;
        if (sum < drg_pkg::TOTAL_MIN)
            sum = drg_pkg::TOTAL_MIN;
        return sum[24:0];
    endfunction

    task automatic push_roll(input logic [7:0] count, input logic signed [15:0] lo,
                             input logic signed [15:0] hi);
        t_roll_req r;
        r.count = count;
        r.lo    = lo;
        r.hi    = hi;
        roll_q.push_back(r);
        rolls_pending++;
        budget += 5 * count + 2 + 40;
    endtask

    task automatic wait_idle();
        while (rolls_pending != 0 || total_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_idle();
        budget += 200;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * drg_pkg::REG_SEED);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        gen_seed = value;
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_roll_req r;
        logic      nxt_valid;
        nxt_valid = i_in_valid;
        if (i_in_valid && o_in_ready) begin
            total_q.push_back(predict_total(i_dice_count, i_low_value, i_high_value));
            rolls_pending--;
            nxt_valid = 1'b0;
            if (!calm && $urandom_range(0, 5) == 0)
                in_gap = $urandom_range(1, 19);
        end
        if (!nxt_valid && i_rst_n) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (roll_q.size() > 0) begin
                r = roll_q.pop_front();
                i_dice_count <= r.count;
                i_low_value  <= r.lo;
                i_high_value <= r.hi;
                nxt_valid    = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
    end

    // result monitor
    always @(posedge i_clk) begin
        logic signed [24:0] want;
        logic               nxt_ready;
        if (o_out_valid && i_out_ready) begin
            if (total_q.size() == 0) begin
                $error("total: unexpected transfer, actual %0d", o_total);
                errors++;
            end else begin
                want = total_q.pop_front();
                if (o_total !== want) begin
                    $error("total: expected %0d, actual %0d", want, o_total);
                    errors++;
                end
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            nxt_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            out_stall = $urandom_range(1, 19) - 1;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
        end
        i_out_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 4 * budget + 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [31:0]        inv;
        logic [31:0]        tgt;
        logic [31:0]        half;
        logic [31:0]        special_seed;
        logic [7:0]         cnt;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        int                 sel;

        // seed whose next step lands at or above the scale divisor
        inv = drg_pkg::MULT_HALF;
        repeat (5) inv = inv * (32'd2 - drg_pkg::MULT_HALF * inv);
        special_seed = 32'hFFFF_FFFF;
        for (int t = 4; t >= 0; t--) begin
            tgt  = 32'hFFFF_FFFB + 32'(t);
            half = (32'd0 - tgt) * inv;
            if (!half[31])
                special_seed = {half[30:0], 1'b0};
            half = (drg_pkg::MULT_ODD - tgt) * inv;
            if (!half[31])
                special_seed = {half[30:0], 1'b1};
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset seed
        push_roll(8'd0,   16'sd1,      16'sd6);
        push_roll(8'd1,   16'sd1,      16'sd6);
        push_roll(8'd3,   16'sd1,      16'sd6);
        push_roll(8'd2,   16'sd1,      16'sd20);
        push_roll(8'd255, 16'sh8000,   16'sh7FFF);
        push_roll(8'd255, 16'sh7FFF,   16'sh7FFF);
        push_roll(8'd255, 16'sh8000,   16'sh8000);
        push_roll(8'd5,   16'sh7FFF,   16'sh8000);
        push_roll(8'd4,   16'sd10,     16'sd9);
        push_roll(8'd4,   16'sd10,     16'sd8);
        push_roll(8'd1,   16'sd0,      16'sd0);
        push_roll(8'd128, 16'sd100,    16'sd200);
        push_roll(8'd7,   -16'sd100,   16'sd100);
        push_roll(8'd0,   16'sh8000,   16'sh7FFF);

        write_seed(32'd0);
        push_roll(8'd3, 16'sd1,  16'sd6);
        push_roll(8'd2, -16'sd7, 16'sd7);

        write_seed(32'hFFFF_FFFF);
        push_roll(8'd10, 16'sd1, 16'sd6);

        write_seed(special_seed);
        push_roll(8'd1, 16'sd1, 16'sd6);
        write_seed(special_seed);
        push_roll(8'd1, 16'sh7FFF, 16'sh7FFF);
        write_seed(special_seed);
        push_roll(8'd1, 16'sd5, -16'sd5);

        for (int chunk = 0; chunk < 6; chunk++) begin
            case (chunk)
                0, 4: write_seed($urandom);
                2:    write_seed(32'h8000_0000);
                5: begin
                    write_seed(drg_pkg::SEED_RESET);
                    calm = 1'b1;
                end
                default: wait_idle();
            endcase
            for (int k = 0; k < 90; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    cnt = 8'd0;
                else if (sel < 75)
                    cnt = 8'($urandom_range(1, 8));
                else if (sel < 93)
                    cnt = 8'($urandom_range(9, 40));
                else if (sel < 98)
                    cnt = 8'($urandom_range(41, 254));
                else
                    cnt = 8'd255;
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    lo = 16'($urandom_range(0, 2));
                    hi = 16'($urandom_range(2, 100));
                end else if (sel < 8) begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                end else if (sel == 8) begin
                    lo = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                    hi = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                end else begin
                    lo = 16'($urandom);
                    hi = lo + 16'($urandom_range(0, 3));
                end
                push_roll(cnt, lo, hi);
            end
        end

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (errors == 0 && total_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (total_q.size() != 0)
                $error("total: %0d transfers never arrived", total_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/drg_pkg.sv
design/dice_roll_generator.sv
tb/tb.sv
